FILE: rtl/frgf_pkg.sv
// Package for the frame resequencer: table sizes, field widths and shared types.
// No dependencies.
`timescale 1ns / 1ps
package frgf_pkg;
    localparam int TableDepth  = 16;
    localparam int IdxBits     = $clog2(TableDepth);
    localparam int NumBits     = 32;
    localparam int TagBits     = 16;
    localparam int GapBits     = 16;
    localparam int FillBits    = 5;
    localparam int CntBits     = $clog2(TableDepth + 1);
    localparam logic [NumBits-1:0] SpanLimit = NumBits'(50);

    localparam logic CfgGapLimit  = 1'b0;
    localparam logic CfgFillLimit = 1'b1;

    // request kinds
    localparam logic ReqFrame = 1'b0;
    localparam logic ReqFlush = 1'b1;

    localparam logic KindFrame = 1'b0;
    localparam logic KindRun   = 1'b1;

    // scan unit operation select
    typedef enum logic [1:0] {
        SCAN_MATCH,   // find valid entry equal to key
        SCAN_LOHI,    // min/max over entries >= key
        SCAN_MIN,     // min over all valid entries
        SCAN_FREE     // first free slot, plus valid count
    } scan_op_t;

    // result of one full scan pass
    typedef struct packed {
        logic               found;
        logic [IdxBits-1:0] idx;
        logic [NumBits-1:0] lo;
        logic [NumBits-1:0] hi;
        logic [CntBits-1:0] count;
    } scan_res_t;
endpackage

FILE: rtl/frgf_scan.sv
// Shared scan unit: walks the table one entry per cycle with a single
// compare path. Depends on frgf_pkg.
`timescale 1ns / 1ps
module frgf_scan (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  frgf_pkg::scan_op_t           op,
    input  logic [frgf_pkg::NumBits-1:0] key,
    input  logic [frgf_pkg::TableDepth-1:0] valid,
    output logic [frgf_pkg::IdxBits-1:0] rd_idx,
    input  logic [frgf_pkg::NumBits-1:0] rd_num,
    output logic                         done,
    output frgf_pkg::scan_res_t          res
);
    logic                         busy_reg, busy_next;
    logic [frgf_pkg::IdxBits-1:0] idx_reg, idx_next;
    frgf_pkg::scan_op_t           op_reg, op_next;
    logic [frgf_pkg::NumBits-1:0] key_reg, key_next;
    frgf_pkg::scan_res_t          res_reg, res_next;
    logic                         done_reg, done_next;
    logic                         ev;

    assign rd_idx = idx_reg;
    assign done   = done_reg;
    assign res    = res_reg;
    assign ev     = valid[idx_reg];

    // one entry per cycle
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        op_next   = op_reg;
        key_next  = key_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = '0;
            op_next   = op;
            key_next  = key;
            res_next  = '0;
        end else if (busy_reg) begin
            unique case (op_reg)
                frgf_pkg::SCAN_MATCH: begin
                    if (ev && rd_num == key_reg && !res_reg.found) begin
                        res_next.found = 1'b1;
                        res_next.idx   = idx_reg;
                    end
                end
                frgf_pkg::SCAN_LOHI: begin
                    if (ev && rd_num >= key_reg) begin
                        if (!res_reg.found || rd_num < res_reg.lo) res_next.lo = rd_num;
                        if (!res_reg.found || rd_num > res_reg.hi) res_next.hi = rd_num;
                        res_next.found = 1'b1;
                    end
                end
                frgf_pkg::SCAN_MIN: begin
                    if (ev && (!res_reg.found || rd_num < res_reg.lo)) begin
                        res_next.lo    = rd_num;
                        res_next.idx   = idx_reg;
                        res_next.found = 1'b1;
                    end
                end
                frgf_pkg::SCAN_FREE: begin
                    if (ev) res_next.count = res_reg.count + 1'b1;
                    else if (!res_reg.found) begin
                        res_next.found = 1'b1;
                        res_next.idx   = idx_reg;
                    end
                end
                default: ;
            endcase
            if (idx_reg == frgf_pkg::IdxBits'(frgf_pkg::TableDepth - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            op_reg   <= frgf_pkg::SCAN_MATCH;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
            op_reg   <= op_next;
        end
        key_reg <= key_next;
        res_reg <= res_next;
    end
endmodule

FILE: rtl/frame_resequencer_gap_fill.sv
// Top level of the frame resequencer with gap fill: sequencer, table and
// result register. Depends on frgf_pkg and frgf_scan.
`timescale 1ns / 1ps
// Usage:
//   s_ channel takes one request: kind 0 stores frame_number/payload_tag,
//   kind 1 flushes the table. s_ready is high only while the block is idle.
//   m_ channel gives the results of that request in order, last marking
//   the final one; a request with no result gives nothing on m_.
//   gap_limit (index 0) and fill_limit (index 1) are written on cfg_ while idle.
//   Every table search is one pass of a shared compare unit over the 16
//   entries. A dropped arrival is done after the free slot search. A
//   stored arrival adds a match search, a drain search and a done state.
//   Each released frame or missing run adds an emit state and a drain
//   search, each drain round that released something a min/max search.
//   A flush adds one min search and one emit state per remaining entry,
//   one more emit state before a hole.
//   Each result waits in a pending register until the next one is known;
//   while m_ready is low a full output register holds and the sequencer waits.
//   Reset empties the table, sets the expected number to zero and the
//   registers to gap_limit 10, fill_limit 16; no clearing pass is needed.
module frame_resequencer_gap_fill (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [frgf_pkg::NumBits-1:0]  s_frame_number,
    input  logic [frgf_pkg::TagBits-1:0]  s_payload_tag,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_result_kind,
    output logic [frgf_pkg::NumBits-1:0]  m_out_number,
    output logic [frgf_pkg::NumBits-1:0]  m_run_length,
    output logic [frgf_pkg::TagBits-1:0]  m_out_tag,
    output logic                          m_last,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [frgf_pkg::GapBits-1:0]  cfg_wdata
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_FREE, ST_MATCH, ST_DRAIN, ST_LOHI, ST_FLUSH_MIN,
        ST_EMIT, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RET_DRAIN, RET_FLUSH, RET_FLUSH_FRAME
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;
    logic   flush_reg, flush_next;
    logic   any_reg, any_next;
    logic   pend_reg, pend_next;

    logic [frgf_pkg::GapBits-1:0]    gap_limit_reg;
    logic [frgf_pkg::FillBits-1:0]   fill_limit_reg;
    logic [frgf_pkg::NumBits-1:0]    expect_reg, expect_next;
    logic [frgf_pkg::TableDepth-1:0] valid_reg, valid_next;
    logic [frgf_pkg::NumBits-1:0]    num_mem [frgf_pkg::TableDepth];
    logic [frgf_pkg::TagBits-1:0]    tag_mem [frgf_pkg::TableDepth];
    logic [frgf_pkg::NumBits-1:0]    in_num_reg, in_num_next;
    logic [frgf_pkg::TagBits-1:0]    in_tag_reg, in_tag_next;
    logic [frgf_pkg::IdxBits-1:0]    free_idx_reg, free_idx_next;
    logic                            num_we, tag_we;
    logic [frgf_pkg::IdxBits-1:0]    wr_idx;

    // newest result, found by the last search
    logic                         n_kind_reg, n_kind_next;
    logic [frgf_pkg::NumBits-1:0] n_num_reg, n_num_next, n_len_reg, n_len_next;
    logic [frgf_pkg::TagBits-1:0] n_tag_reg, n_tag_next;

    // pending result, held until it is known whether it is the last one
    logic                         p_kind_reg, p_kind_next;
    logic [frgf_pkg::NumBits-1:0] p_num_reg, p_num_next, p_len_reg, p_len_next;
    logic [frgf_pkg::TagBits-1:0] p_tag_reg, p_tag_next;

    // frame that follows a hole run in a flush
    logic [frgf_pkg::NumBits-1:0] h_num_reg, h_num_next;
    logic [frgf_pkg::TagBits-1:0] h_tag_reg, h_tag_next;

    logic                         o_valid_reg, o_kind_reg, o_last_reg;
    logic [frgf_pkg::NumBits-1:0] o_num_reg, o_len_reg;
    logic [frgf_pkg::TagBits-1:0] o_tag_reg;
    logic                         o_load, o_last_next;

    // scan start requests issued from the sequencer
    logic                         go_reg, go_next;
    frgf_pkg::scan_op_t           go_op_reg, go_op_next;
    logic [frgf_pkg::NumBits-1:0] go_key_reg, go_key_next;

    logic [frgf_pkg::IdxBits-1:0]  sc_idx;
    logic                          sc_done;
    frgf_pkg::scan_res_t           sc_res;
    logic [frgf_pkg::FillBits-1:0] limit;
    logic                          o_free;
    logic                          skip;

    assign limit = (fill_limit_reg > frgf_pkg::FillBits'(frgf_pkg::TableDepth))
                   ? frgf_pkg::FillBits'(frgf_pkg::TableDepth) : fill_limit_reg;
    assign o_free  = !o_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // hole before the smallest waiting number is too large and the span too wide
    assign skip = sc_res.found &&
                  (sc_res.lo - expect_reg) > frgf_pkg::NumBits'(gap_limit_reg) &&
                  (sc_res.hi - sc_res.lo) > frgf_pkg::SpanLimit;

    assign m_valid       = o_valid_reg;
    assign m_result_kind = o_kind_reg;
    assign m_out_number  = o_num_reg;
    assign m_run_length  = o_len_reg;
    assign m_out_tag     = o_tag_reg;
    assign m_last        = o_last_reg;

    frgf_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (go_reg),
        .op      (go_op_reg),
        .key     (go_key_reg),
        .valid   (valid_reg),
        .rd_idx  (sc_idx),
        .rd_num  (num_mem[sc_idx]),
        .done    (sc_done),
        .res     (sc_res)
    );

    // sequencer next state
    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        flush_next    = flush_reg;
        any_next      = any_reg;
        pend_next     = pend_reg;
        expect_next   = expect_reg;
        valid_next    = valid_reg;
        in_num_next   = in_num_reg;
        in_tag_next   = in_tag_reg;
        free_idx_next = free_idx_reg;
        n_kind_next   = n_kind_reg;
        n_num_next    = n_num_reg;
        n_len_next    = n_len_reg;
        n_tag_next    = n_tag_reg;
        p_kind_next   = p_kind_reg;
        p_num_next    = p_num_reg;
        p_len_next    = p_len_reg;
        p_tag_next    = p_tag_reg;
        h_num_next    = h_num_reg;
        h_tag_next    = h_tag_reg;
        go_next       = 1'b0;
        go_op_next    = go_op_reg;
        go_key_next   = go_key_reg;
        num_we        = 1'b0;
        tag_we        = 1'b0;
        wr_idx        = free_idx_reg;
        o_load        = 1'b0;
        o_last_next   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_num_next = s_frame_number;
                    in_tag_next = s_payload_tag;
                    flush_next  = (s_kind == frgf_pkg::ReqFlush);
                    any_next    = 1'b0;
                    go_next     = 1'b1;
                    if (s_kind == frgf_pkg::ReqFlush) begin
                        go_op_next  = frgf_pkg::SCAN_MATCH;
                        go_key_next = expect_reg;
                        state_next  = ST_DRAIN;
                    end else begin
                        go_op_next = frgf_pkg::SCAN_FREE;
                        state_next = ST_FREE;
                    end
                end
            end
            ST_FREE: begin
                if (sc_done) begin
                    if (frgf_pkg::FillBits'(sc_res.count) >= limit) begin
                        state_next = ST_IDLE;
                    end else begin
                        free_idx_next = sc_res.idx;
                        go_next       = 1'b1;
                        go_op_next    = frgf_pkg::SCAN_MATCH;
                        go_key_next   = in_num_reg;
                        state_next    = ST_MATCH;
                    end
                end
            end
            ST_MATCH: begin
                if (sc_done) begin
                    tag_we = 1'b1;
                    if (sc_res.found) begin
                        wr_idx = sc_res.idx;
                    end else begin
                        valid_next[free_idx_reg] = 1'b1;
                        num_we = 1'b1;
                    end
                    go_next     = 1'b1;
                    go_op_next  = frgf_pkg::SCAN_MATCH;
                    go_key_next = expect_reg;
                    state_next  = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (sc_done) begin
                    if (sc_res.found) begin
                        n_kind_next = frgf_pkg::KindFrame;
                        n_num_next  = num_mem[sc_res.idx];
                        n_len_next  = frgf_pkg::NumBits'(1);
                        n_tag_next  = tag_mem[sc_res.idx];
                        valid_next[sc_res.idx] = 1'b0;
                        expect_next = expect_reg + 1'b1;
                        any_next    = 1'b1;
                        ret_next    = RET_DRAIN;
                        state_next  = ST_EMIT;
                    end else if (any_reg) begin
                        any_next    = 1'b0;
                        go_next     = 1'b1;
                        go_op_next  = frgf_pkg::SCAN_LOHI;
                        go_key_next = expect_reg;
                        state_next  = ST_LOHI;
                    end else if (flush_reg) begin
                        go_next    = 1'b1;
                        go_op_next = frgf_pkg::SCAN_MIN;
                        state_next = ST_FLUSH_MIN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOHI: begin
                if (sc_done) begin
                    if (skip) begin
                        n_kind_next = frgf_pkg::KindRun;
                        n_num_next  = expect_reg;
                        n_len_next  = sc_res.lo - expect_reg;
                        n_tag_next  = '0;
                        expect_next = sc_res.lo;
                        ret_next    = RET_DRAIN;
                        state_next  = ST_EMIT;
                    end else if (flush_reg) begin
                        go_next    = 1'b1;
                        go_op_next = frgf_pkg::SCAN_MIN;
                        state_next = ST_FLUSH_MIN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FLUSH_MIN: begin
                if (sc_done) begin
                    if (!sc_res.found) begin
                        state_next = ST_DONE;
                    end else begin
                        valid_next[sc_res.idx] = 1'b0;
                        h_num_next = sc_res.lo;
                        h_tag_next = tag_mem[sc_res.idx];
                        if (sc_res.lo > expect_reg) begin
                            n_kind_next = frgf_pkg::KindRun;
                            n_num_next  = expect_reg;
                            n_len_next  = sc_res.lo - expect_reg;
                            n_tag_next  = '0;
                            ret_next    = RET_FLUSH_FRAME;
                        end else begin
                            n_kind_next = frgf_pkg::KindFrame;
                            n_num_next  = sc_res.lo;
                            n_len_next  = frgf_pkg::NumBits'(1);
                            n_tag_next  = tag_mem[sc_res.idx];
                            ret_next    = RET_FLUSH;
                        end
                        // late entries leave the expected number alone
                        if (sc_res.lo >= expect_reg) expect_next = sc_res.lo + 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                // previous pending result goes out, the newest one becomes pending
                if (!pend_reg || o_free) begin
                    o_load      = pend_reg;
                    p_kind_next = n_kind_reg;
                    p_num_next  = n_num_reg;
                    p_len_next  = n_len_reg;
                    p_tag_next  = n_tag_reg;
                    pend_next   = 1'b1;
                    unique case (ret_reg)
                        RET_DRAIN: begin
                            go_next     = 1'b1;
                            go_op_next  = frgf_pkg::SCAN_MATCH;
                            go_key_next = expect_reg;
                            state_next  = ST_DRAIN;
                        end
                        RET_FLUSH: begin
                            go_next    = 1'b1;
                            go_op_next = frgf_pkg::SCAN_MIN;
                            state_next = ST_FLUSH_MIN;
                        end
                        RET_FLUSH_FRAME: begin
                            // the frame after the hole run is the next result
                            n_kind_next = frgf_pkg::KindFrame;
                            n_num_next  = h_num_reg;
                            n_len_next  = frgf_pkg::NumBits'(1);
                            n_tag_next  = h_tag_reg;
                            ret_next    = RET_FLUSH;
                            state_next  = ST_EMIT;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_DONE: begin
                if (!pend_reg) begin
                    state_next = ST_IDLE;
                end else if (o_free) begin
                    o_load      = 1'b1;
                    o_last_next = 1'b1;
                    pend_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer registers, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ret_reg        <= RET_DRAIN;
            flush_reg      <= 1'b0;
            any_reg        <= 1'b0;
            pend_reg       <= 1'b0;
            valid_reg      <= '0;
            expect_reg     <= '0;
            gap_limit_reg  <= frgf_pkg::GapBits'(10);
            fill_limit_reg <= frgf_pkg::FillBits'(16);
            o_valid_reg    <= 1'b0;
            go_reg         <= 1'b0;
            go_op_reg      <= frgf_pkg::SCAN_MATCH;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            flush_reg  <= flush_next;
            any_reg    <= any_next;
            pend_reg   <= pend_next;
            valid_reg  <= valid_next;
            expect_reg <= expect_next;
            go_reg     <= go_next;
            go_op_reg  <= go_op_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    frgf_pkg::CfgGapLimit:  gap_limit_reg  <= cfg_wdata;
                    frgf_pkg::CfgFillLimit: fill_limit_reg <= cfg_wdata[frgf_pkg::FillBits-1:0];
                    default: ;
                endcase
            end
            if (o_load) o_valid_reg <= 1'b1;
            else if (m_ready) o_valid_reg <= 1'b0;
        end
        in_num_reg   <= in_num_next;
        in_tag_reg   <= in_tag_next;
        free_idx_reg <= free_idx_next;
        go_key_reg   <= go_key_next;
        n_kind_reg   <= n_kind_next;
        n_num_reg    <= n_num_next;
        n_len_reg    <= n_len_next;
        n_tag_reg    <= n_tag_next;
        p_kind_reg   <= p_kind_next;
        p_num_reg    <= p_num_next;
        p_len_reg    <= p_len_next;
        p_tag_reg    <= p_tag_next;
        h_num_reg    <= h_num_next;
        h_tag_reg    <= h_tag_next;
        if (o_load) begin
            o_last_reg <= o_last_next;
            o_kind_reg <= p_kind_reg;
            o_num_reg  <= p_num_reg;
            o_len_reg  <= p_len_reg;
            o_tag_reg  <= p_tag_reg;
        end
    end

    // table storage
    always_ff @(posedge aclk) begin
        if (num_we) num_mem[wr_idx] <= in_num_reg;
        if (tag_we) tag_mem[wr_idx] <= in_tag_reg;
    end
endmodule
